// ----- design/fbf_pkg.sv -----
// Shared types, codes and constants of the fast block FIR filter.
package fbf_pkg;

    localparam int OUT_BITS   = 36;
    localparam int HIST_DEPTH = 4;
    localparam int NEW_LANES  = 4;
    localparam int WIN_DEPTH  = HIST_DEPTH + NEW_LANES;
    localparam int NUM_PROD   = 9;
    localparam int CFG_IDX_BITS = 3;
    localparam int LANES_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF0 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF1 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF2 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF3 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF4 = 3'd5;

    localparam logic [LANES_BITS-1:0] LANES_TWO  = 3'd2;
    localparam logic [LANES_BITS-1:0] LANES_FOUR = 3'd4;

    typedef enum logic [2:0] {
        MODE_TAP2   = 3'd0,
        MODE_TAP3   = 3'd1,
        MODE_TAP4X4 = 3'd2,
        MODE_TAP4X2 = 3'd3,
        MODE_TAP5   = 3'd4
    } mode_t;

    // unknown codes fall back to the two-tap form
    function automatic mode_t decode_mode(logic [2:0] code);
        mode_t m;
        unique case (code)
            3'd1:    m = MODE_TAP3;
            3'd2:    m = MODE_TAP4X4;
            3'd3:    m = MODE_TAP4X2;
            3'd4:    m = MODE_TAP5;
            default: m = MODE_TAP2;
        endcase
        return m;
    endfunction

endpackage

// ----- design/fbf_interfaces.sv -----
// Valid/ready stream interfaces for sample items and result items.
interface fbf_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_lane0;
    logic signed [SAMPLE_BITS-1:0] sample_lane1;
    logic signed [SAMPLE_BITS-1:0] sample_lane2;
    logic signed [SAMPLE_BITS-1:0] sample_lane3;

    modport source (
        output valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
        input  ready
    );
    modport sink (
        input  valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
        output ready
    );
endinterface

interface fbf_out_if;
    import fbf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] result_lane0;
    logic signed [OUT_BITS-1:0] result_lane1;
    logic signed [OUT_BITS-1:0] result_lane2;
    logic signed [OUT_BITS-1:0] result_lane3;
    logic [LANES_BITS-1:0]      lanes_valid;

    modport source (
        output valid, result_lane0, result_lane1, result_lane2, result_lane3,
               lanes_valid,
        input  ready
    );
    modport sink (
        input  valid, result_lane0, result_lane1, result_lane2, result_lane3,
               lanes_valid,
        output ready
    );
endinterface

// ----- design/fast_block_fir_filter.sv -----
// Fast block FIR filter top level: window register, product stage, result stage.
// An accepted item reaches result valid through the window, product and result registers.
// Throughput: one item per cycle; the three register stages stall together
// when a result waits at the output.
// Reset: sample history, coefficients and mode clear to zero (two-tap form),
// all stage valid flags clear.
module fast_block_fir_filter #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fbf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [COEF_BITS-1:0]               cfg_data,
    fbf_in_if.sink                             samples,
    fbf_out_if.source                          results
);
    import fbf_pkg::*;

    localparam int DATA_BITS = SAMPLE_BITS + 2;
    localparam int CSUM_BITS = COEF_BITS + 2;
    localparam int PROD_BITS = DATA_BITS + CSUM_BITS;
    localparam int SUM_BITS  = PROD_BITS + 3;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // configuration
    logic [2:0]                  mode_reg;
    logic signed [COEF_BITS-1:0] coef_reg [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg    <= cfg_data[2:0];
                CFG_COEF0: coef_reg[0] <= cfg_data;
                CFG_COEF1: coef_reg[1] <= cfg_data;
                CFG_COEF2: coef_reg[2] <= cfg_data;
                CFG_COEF3: coef_reg[3] <= cfg_data;
                CFG_COEF4: coef_reg[4] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // pipeline control
    logic  v1_reg, v2_reg, v3_reg;
    logic  adv;
    logic  accept;
    mode_t mode_in;

    assign adv           = !v3_reg || results.ready;
    assign samples.ready = adv;
    assign accept        = samples.valid && adv;
    assign mode_in       = decode_mode(mode_reg);

    // sample history
    logic signed [SAMPLE_BITS-1:0] hist_reg  [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_next [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] lane_in   [NEW_LANES];

    assign lane_in[0] = samples.sample_lane0;
    assign lane_in[1] = samples.sample_lane1;
    assign lane_in[2] = samples.sample_lane2;
    assign lane_in[3] = samples.sample_lane3;

    always_comb
    begin
        if (mode_in == MODE_TAP4X4)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = lane_in[i];
            end
        end
        else
        begin
            hist_next[0] = hist_reg[2];
            hist_next[1] = hist_reg[3];
            hist_next[2] = lane_in[0];
            hist_next[3] = lane_in[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
        end
    end

    // stage 1: sample window, history first
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN_DEPTH];
    mode_t                         mode1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                win_reg[i] <= hist_reg[i];
            end
            for (int i = 0; i < NEW_LANES; i++)
            begin
                win_reg[HIST_DEPTH+i] <= lane_in[i];
            end
            mode1_reg <= mode_in;
        end
    end

    // stage 2: pre-adds and products
    logic signed [DATA_BITS-1:0] w   [WIN_DEPTH];
    logic signed [CSUM_BITS-1:0] h   [5];
    logic signed [DATA_BITS-1:0] opd [NUM_PROD];
    logic signed [CSUM_BITS-1:0] opc [NUM_PROD];
    logic signed [DATA_BITS-1:0] ta, tb, tc, ua, ub, uc;
    logic signed [PROD_BITS-1:0] prod_next [NUM_PROD];
    logic signed [PROD_BITS-1:0] prod_reg  [NUM_PROD];
    mode_t                       mode2_reg;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            w[i] = DATA_BITS'(win_reg[i]);
        end
        for (int i = 0; i < 5; i++)
        begin
            h[i] = CSUM_BITS'(coef_reg[i]);
        end
        for (int k = 0; k < NUM_PROD; k++)
        begin
            opd[k] = '0;
            opc[k] = '0;
        end
        ta = w[1] - w[3];
        tb = w[2] - w[4];
        tc = w[3] - w[5];
        ua = w[3] - w[5];
        ub = w[4] - w[6];
        uc = w[5] - w[7];
        unique case (mode1_reg)
            MODE_TAP2:
            begin
                opd[0] = w[3] - w[4];  opc[0] = h[1];
                opd[1] = w[4];         opc[1] = h[0] + h[1];
                opd[2] = w[4] - w[5];  opc[2] = h[0];
            end
            MODE_TAP3:
            begin
                opd[0] = w[2] - w[4];  opc[0] = h[2];
                opd[1] = w[3] + w[4];  opc[1] = h[0] + h[1] + h[2];
                opd[2] = w[4] - w[3];  opc[2] = h[0] - h[1] + h[2];
                opd[3] = w[3] - w[5];  opc[3] = h[0];
            end
            MODE_TAP4X2:
            begin
                opd[0] = w[1] - w[2];  opc[0] = h[3];
                opd[1] = w[2];         opc[1] = h[2] + h[3];
                opd[2] = w[2] - w[3];  opc[2] = h[2];
                opd[3] = w[3] - w[4];  opc[3] = h[1];
                opd[4] = w[4];         opc[4] = h[0] + h[1];
                opd[5] = w[4] - w[5];  opc[5] = h[0];
            end
            MODE_TAP5:
            begin
                opd[0] = w[0] - w[1];  opc[0] = h[4];
                opd[1] = w[1];         opc[1] = h[3] + h[4];
                opd[2] = w[1] - w[2];  opc[2] = h[3];
                opd[3] = w[2] - w[4];  opc[3] = h[2];
                opd[4] = w[3] + w[4];  opc[4] = h[0] + h[1] + h[2];
                opd[5] = w[4] - w[3];  opc[5] = h[0] - h[1] + h[2];
                opd[6] = w[3] - w[5];  opc[6] = h[0];
            end
            MODE_TAP4X4:
            begin
                opd[0] = ta - tb;      opc[0] = h[3];
                opd[1] = tb;           opc[1] = h[2] + h[3];
                opd[2] = tb - tc;      opc[2] = h[2];
                opd[3] = w[3] - w[4];  opc[3] = h[1] + h[3];
                opd[4] = w[4];         opc[4] = h[0] + h[1] + h[2] + h[3];
                opd[5] = w[4] - w[5];  opc[5] = h[0] + h[2];
                opd[6] = ua - ub;      opc[6] = h[1];
                opd[7] = ub;           opc[7] = h[0] + h[1];
                opd[8] = ub - uc;      opc[8] = h[0];
            end
            default: ;
        endcase
        for (int k = 0; k < NUM_PROD; k++)
        begin
            prod_next[k] = PROD_BITS'(opd[k]) * PROD_BITS'(opc[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            mode2_reg <= mode1_reg;
        end
    end

    // stage 3: post-adds, saturation, result register
    logic signed [SUM_BITS-1:0] q [NUM_PROD];
    logic signed [SUM_BITS-1:0] y [4];
    logic signed [OUT_BITS-1:0] sat_next [4];
    logic signed [OUT_BITS-1:0] res_reg  [4];
    logic [LANES_BITS-1:0]      lanes_next;
    logic [LANES_BITS-1:0]      lanes_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_PROD; k++)
        begin
            q[k] = SUM_BITS'(prod_reg[k]);
        end
        for (int i = 0; i < 4; i++)
        begin
            y[i] = '0;
        end
        lanes_next = LANES_TWO;
        // even and odd sums of the three-tap form are exact multiples of two
        unique case (mode2_reg)
            MODE_TAP2:
            begin
                y[0] = q[0] + q[1];
                y[1] = q[1] - q[2];
            end
            MODE_TAP3:
            begin
                y[0] = q[0] + ((q[1] + q[2]) >>> 1);
                y[1] = ((q[1] - q[2]) >>> 1) - q[3];
            end
            MODE_TAP4X2:
            begin
                y[0] = q[0] + q[1] + q[3] + q[4];
                y[1] = q[1] - q[2] + q[4] - q[5];
            end
            MODE_TAP5:
            begin
                y[0] = q[0] + q[1] + q[3] + ((q[4] + q[5]) >>> 1);
                y[1] = q[1] - q[2] + ((q[4] - q[5]) >>> 1) - q[6];
            end
            MODE_TAP4X4:
            begin
                y[0] = q[0] + q[1] + q[3] + q[4];
                y[1] = q[1] - q[2] + q[4] - q[5];
                y[2] = q[3] + q[4] - q[6] - q[7];
                y[3] = q[4] - q[5] - q[7] + q[8];
                lanes_next = LANES_FOUR;
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_sat
        if (SUM_BITS > OUT_BITS)
        begin : g_clamp
            always_comb
            begin
                if (&y[g][SUM_BITS-1:OUT_BITS-1] || ~|y[g][SUM_BITS-1:OUT_BITS-1])
                begin
                    sat_next[g] = y[g][OUT_BITS-1:0];
                end
                else if (y[g][SUM_BITS-1])
                begin
                    sat_next[g] = OUT_MIN;
                end
                else
                begin
                    sat_next[g] = OUT_MAX;
                end
            end
        end
        else
        begin : g_extend
            assign sat_next[g] = OUT_BITS'(y[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= sat_next;
            lanes_reg <= lanes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= samples.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign results.valid        = v3_reg;
    assign results.result_lane0 = res_reg[0];
    assign results.result_lane1 = res_reg[1];
    assign results.result_lane2 = res_reg[2];
    assign results.result_lane3 = res_reg[3];
    assign results.lanes_valid  = lanes_reg;

`ifndef SYNTH
    a_two_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && lanes_reg == LANES_TWO) |-> (res_reg[2] == '0 && res_reg[3] == '0))
        else $error("unused result lanes not zero");

    a_lanes_code: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (lanes_reg == LANES_TWO || lanes_reg == LANES_FOUR))
        else $error("bad lane count on result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> v1_reg)
        else $error("accepted item lost at stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !results.ready) |=> ($stable(v1_reg) && $stable(v2_reg) && v3_reg))
        else $error("pipeline moved during output stall");

    a_history_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.valid && samples.ready) |=> $stable(hist_reg[3]))
        else $error("history changed without an item");
`endif

endmodule
